>>> hw/rtl/frasm_pkg.sv
package frasm_pkg;

    // Operation codes on the request channel
    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    // Status codes on the response channel
    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_RESTART  = 2'd2,
        ST_READ     = 2'd3
    } t_status;

    // Frame header layout
    localparam int HDR_LEN   = 4;
    localparam int HDR_INDEX = 0;
    localparam int HDR_TOTAL = 1;
    localparam int HDR_EP    = 2;
    localparam int HDR_PROTO = 3;

    localparam int ENDPOINT_MAX = 15;
    localparam int POS_MAX      = 255;

    // Response queue depth: covers one result in flight plus two waiting
    localparam int OUTQ_DEPTH = 3;

    typedef struct packed {
        t_status    status;
        logic [7:0] read_data;
        logic [7:0] report_length;
        logic [3:0] endpoint;
        logic [7:0] protocol_code;
        logic [7:0] received_count;
    } t_result;

endpackage

>>> hw/rtl/frasm_if.sv
interface frasm_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] frame_byte;
    logic       frame_last;
    logic [7:0] read_index;

    modport source (
        output valid, operation, frame_byte, frame_last, read_index,
        input  ready
    );
    modport sink (
        input  valid, operation, frame_byte, frame_last, read_index,
        output ready
    );
endinterface

interface frasm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] read_data;
    logic [7:0] report_length;
    logic [3:0] endpoint;
    logic [7:0] protocol_code;
    logic [7:0] received_count;

    modport source (
        output valid, status, read_data, report_length, endpoint, protocol_code,
               received_count,
        input  ready
    );
    modport sink (
        input  valid, status, read_data, report_length, endpoint, protocol_code,
               received_count,
        output ready
    );
endinterface

>>> hw/rtl/frasm_outq.sv
module frasm_outq
    import frasm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_data,
    output logic [1:0]         o_count,
    frasm_out_if.source        o_rsp
);

    t_result    r_q [OUTQ_DEPTH];
    logic [1:0] r_head;
    logic [1:0] r_tail;
    logic [1:0] r_count;
    logic [1:0] n_head;
    logic [1:0] n_tail;
    logic [1:0] n_count;
    logic       pop;
    t_result    head_data;

    assign pop       = o_rsp.valid && o_rsp.ready;
    assign head_data = r_q[r_head];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (pop) begin
            n_head = (r_head == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : r_head + 2'd1;
        end
        if (i_push) begin
            n_tail = (r_tail == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : r_tail + 2'd1;
        end
        case ({i_push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Hold entries until popped
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_tail] <= i_data;
        end
    end

    assign o_count              = r_count;
    assign o_rsp.valid          = (r_count != 2'd0);
    assign o_rsp.status         = head_data.status;
    assign o_rsp.read_data      = head_data.read_data;
    assign o_rsp.report_length  = head_data.report_length;
    assign o_rsp.endpoint       = head_data.endpoint;
    assign o_rsp.protocol_code  = head_data.protocol_code;
    assign o_rsp.received_count = head_data.received_count;

endmodule

>>> hw/rtl/fragment_reassembler.sv
// Channel | Dir | Modport            | Payload
// i_req   | in  | frasm_in_if.sink   | operation, frame_byte, frame_last, read_index
// o_rsp   | out | frasm_out_if.source| status, read_data, report_length, endpoint,
//         |     |                    | protocol_code, received_count
//
// One transaction per cycle on i_req while i_req.ready is high; each result passes through
// one pipeline register with the store read, then the response queue, on its way to o_rsp.
// Frame bytes that are not last give no result. The pace is set by the three-entry
// response queue: i_req.ready drops while queued plus in-flight results reach three.
// Synchronous active-low reset clears the frame counter, header and context;
// the report store is not cleared.
module fragment_reassembler
    import frasm_pkg::*;
#(
    parameter int DATA_PER_FRAGMENT = 28,
    parameter int MAX_REPORT        = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    frasm_in_if.sink     i_req,
    frasm_out_if.source  o_rsp
);

    localparam int AW    = (MAX_REPORT > 1) ? $clog2(MAX_REPORT) : 1;
    localparam int DPF_W = $clog2(DATA_PER_FRAGMENT + 1);
    localparam int OFS_W = 8 + DPF_W;

    // Frame and context state
    logic [7:0]       r_frame_pos;
    logic [7:0]       r_hdr [HDR_LEN];
    logic [OFS_W-1:0] r_offset;
    logic [7:0]       r_len;
    logic [7:0]       r_done;
    logic [7:0]       r_next_index;
    logic [3:0]       r_ep;
    logic [7:0]       r_proto;
    logic             r_assembling;

    logic [7:0]       n_frame_pos;
    logic [7:0]       n_len;
    logic [7:0]       n_done;
    logic [7:0]       n_next_index;
    logic [3:0]       n_ep;
    logic [7:0]       n_proto;
    logic             n_assembling;
    logic [OFS_W-1:0] n_offset;
    t_status          n_status;

    // Pipeline stage and store
    logic             r_p_valid;
    t_result          r_p_res;
    logic             r_p_rd_use;
    logic [7:0]       r_mem_q;
    logic [7:0]       r_mem [MAX_REPORT];

    logic             acc;
    logic             is_frame;
    logic             is_read;
    logic             in_header;
    logic [7:0]       data_ofs;
    logic [OFS_W:0]   wr_addr_full;
    logic             wr_en;
    logic             rd_in_range;
    logic [7:0]       hdr_idx;
    logic [7:0]       hdr_total;
    logic [7:0]       hdr_ep;
    logic [7:0]       hdr_proto;
    logic             too_short;
    logic             too_long;
    logic             hdr_bad;
    logic             ofs_past;
    logic [7:0]       remain;
    logic [7:0]       expect_len;
    logic [7:0]       payload_len;
    logic             len_bad;
    logic             seq_bad;
    logic             fault;
    logic [7:0]       done_new;
    logic [1:0]       q_count;
    t_result          push_data;

    assign acc      = i_req.valid && i_req.ready;
    assign is_frame = acc && (t_op'(i_req.operation) == OP_FRAME);
    assign is_read  = acc && (t_op'(i_req.operation) == OP_READ);

    // Accept while the queue can hold every result already in flight
    assign i_req.ready = ({1'b0, q_count} + {2'b00, r_p_valid}) <= 3'(OUTQ_DEPTH - 1);

    // Store address for a data byte
    assign in_header    = r_frame_pos < 8'(HDR_LEN);
    assign data_ofs     = r_frame_pos - 8'(HDR_LEN);
    assign wr_addr_full = {1'b0, r_offset} + (OFS_W + 1)'(data_ofs);
    assign wr_en        = is_frame && !in_header
                          && (wr_addr_full < (OFS_W + 1)'(MAX_REPORT));
    assign rd_in_range  = i_req.read_index < 8'(MAX_REPORT);

    // Fragment offset, taken when the index byte arrives
    assign n_offset = {{DPF_W{1'b0}}, i_req.frame_byte} * OFS_W'(DATA_PER_FRAGMENT);

    // Frame checks at the last byte
    assign hdr_idx     = r_hdr[HDR_INDEX];
    assign hdr_total   = r_hdr[HDR_TOTAL];
    assign hdr_ep      = r_hdr[HDR_EP];
    assign hdr_proto   = r_hdr[HDR_PROTO];
    assign too_short   = in_header;
    assign too_long    = (r_frame_pos == 8'(POS_MAX));
    assign hdr_bad     = (hdr_total == 8'd0) || (hdr_total > 8'(MAX_REPORT))
                         || (hdr_ep == 8'd0) || (hdr_ep > 8'(ENDPOINT_MAX));
    assign ofs_past    = r_offset >= OFS_W'(hdr_total);
    assign remain      = hdr_total - r_offset[7:0];
    assign expect_len  = (remain > 8'(DATA_PER_FRAGMENT)) ? 8'(DATA_PER_FRAGMENT) : remain;
    assign payload_len = r_frame_pos - 8'(HDR_LEN - 1);
    assign len_bad     = (payload_len != expect_len);
    assign seq_bad     = (hdr_idx != 8'd0)
                         && (!r_assembling || (hdr_idx != r_next_index)
                             || (hdr_total != r_len) || (hdr_ep != {4'b0000, r_ep})
                             || (hdr_proto != r_proto));
    assign fault       = too_short || too_long || hdr_bad || ofs_past || len_bad || seq_bad;
    assign done_new    = r_offset[7:0] + payload_len;

    // Next context and status
    always_comb begin
        n_frame_pos  = r_frame_pos;
        n_len        = r_len;
        n_done       = r_done;
        n_next_index = r_next_index;
        n_ep         = r_ep;
        n_proto      = r_proto;
        n_assembling = r_assembling;
        n_status     = ST_READ;
        if (is_frame) begin
            if (!i_req.frame_last) begin
                if (r_frame_pos != 8'(POS_MAX)) begin
                    n_frame_pos = r_frame_pos + 8'd1;
                end
            end else begin
                n_frame_pos = '0;
                if (fault) begin
                    n_len        = '0;
                    n_done       = '0;
                    n_next_index = '0;
                    n_ep         = '0;
                    n_proto      = '0;
                    n_assembling = 1'b0;
                    n_status     = ST_RESTART;
                end else begin
                    if (hdr_idx == 8'd0) begin
                        n_len   = hdr_total;
                        n_ep    = hdr_ep[3:0];
                        n_proto = hdr_proto;
                    end
                    n_done       = done_new;
                    n_next_index = hdr_idx + 8'd1;
                    n_assembling = (done_new != hdr_total);
                    n_status     = (done_new == hdr_total) ? ST_COMPLETE : ST_PROGRESS;
                end
            end
        end
    end

    // Control state and pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pos  <= '0;
            r_len        <= '0;
            r_done       <= '0;
            r_next_index <= '0;
            r_ep         <= '0;
            r_proto      <= '0;
            r_assembling <= 1'b0;
            r_p_valid    <= 1'b0;
            for (int k = 0; k < HDR_LEN; k++) begin
                r_hdr[k] <= '0;
            end
        end else begin
            r_frame_pos  <= n_frame_pos;
            r_len        <= n_len;
            r_done       <= n_done;
            r_next_index <= n_next_index;
            r_ep         <= n_ep;
            r_proto      <= n_proto;
            r_assembling <= n_assembling;
            r_p_valid    <= is_read || (is_frame && i_req.frame_last);
            if (is_frame && in_header) begin
                r_hdr[r_frame_pos[1:0]] <= i_req.frame_byte;
            end
        end
    end

    // Hold offset and the staged result payload
    always_ff @(posedge i_clk) begin
        if (is_frame && (r_frame_pos == 8'd0)) begin
            r_offset <= n_offset;
        end
        if (acc) begin
            r_p_res.status         <= n_status;
            r_p_res.read_data      <= '0;
            r_p_res.report_length  <= n_len;
            r_p_res.endpoint       <= n_ep;
            r_p_res.protocol_code  <= n_proto;
            r_p_res.received_count <= n_done;
            r_p_rd_use             <= is_read && rd_in_range;
        end
    end

    // Report store: write data bytes, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr_full[AW-1:0]] <= i_req.frame_byte;
        end
        if (is_read && rd_in_range) begin
            r_mem_q <= r_mem[i_req.read_index[AW-1:0]];
        end
    end

    // Merge read data into the staged result
    always_comb begin
        push_data           = r_p_res;
        push_data.read_data = r_p_rd_use ? r_mem_q : 8'd0;
    end

    frasm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p_valid),
        .i_data  (push_data),
        .o_count (q_count),
        .o_rsp   (o_rsp)
    );

endmodule

>>> verif/tb_fragment_reassembler.sv
module tb_fragment_reassembler;
    import frasm_pkg::*;

    localparam int FRAG_DATA     = 28;
    localparam int REPORT_MAX    = 64;
    localparam int RA_W          = $clog2(REPORT_MAX);
    localparam int STIM_ITEMS    = 1850;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int DRAIN_CYCLES  = 16;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
        logic [7:0] ridx;
    } frag_req_t;

    typedef struct {
        frag_req_t req;
        bit        typed;
        t_result   res;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    frasm_in_if  req_if ();
    frasm_out_if rsp_if ();

    fragment_reassembler #(
        .DATA_PER_FRAGMENT (FRAG_DATA),
        .MAX_REPORT        (REPORT_MAX)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Reassembly context as the block should hold it
    logic [7:0] frm_pos   = '0;
    logic [7:0] hdr [4]   = '{default: '0};
    logic [7:0] ctx_len   = '0;
    logic [7:0] ctx_done  = '0;
    logic [7:0] ctx_next  = '0;
    logic [3:0] ctx_ep    = '0;
    logic [7:0] ctx_proto = '0;
    logic       ctx_open  = 1'b0;
    logic [7:0] store_data [REPORT_MAX];
    bit   [REPORT_MAX-1:0] store_written = '0;

    t_result pending_results [$];
    t_result front_res;
    int      error_count = 0;
    int      sent_items  = 0;
    int      status_seen [4] = '{default: 0};
    int      idle_cycles = 0;
    int      sink_wait   = 0;
    bit      steady_run  = 1'b0;

    // Directed transactions; typed results only where they are obvious
    dir_row_t directed_rows [20] = '{
        // read out of range right after reset
        '{'{OP_READ,  8'h00, 1'b0, 8'd200}, 1'b1, '{ST_READ, 8'h00, 8'd0, 4'd0, 8'd0, 8'd0}},
        // one-byte frame is too short
        '{'{OP_FRAME, 8'hFF, 1'b1, 8'd0}, 1'b1, '{ST_RESTART, 8'h00, 8'd0, 4'd0, 8'd0, 8'd0}},
        // one-byte report, endpoint 15, protocol 0xFF, with a read inside the frame
        '{'{OP_FRAME, 8'h00, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'h01, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_READ,  8'h00, 1'b0, 8'd254}, 1'b1, '{ST_READ, 8'h00, 8'd0, 4'd0, 8'd0, 8'd0}},
        '{'{OP_FRAME, 8'h0F, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'hFF, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'hA5, 1'b1, 8'd0}, 1'b1, '{ST_COMPLETE, 8'h00, 8'd1, 4'd15, 8'hFF, 8'd1}},
        '{'{OP_READ,  8'h00, 1'b0, 8'd0}, 1'b1, '{ST_READ, 8'hA5, 8'd1, 4'd15, 8'hFF, 8'd1}},
        // endpoint zero in the header
        '{'{OP_FRAME, 8'h00, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'h01, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'h00, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'h07, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'h3C, 1'b1, 8'd0}, 1'b1, '{ST_RESTART, 8'h00, 8'd0, 4'd0, 8'd0, 8'd0}},
        // fragment 1 with no report open
        '{'{OP_FRAME, 8'h01, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'h1D, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'h03, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'h09, 1'b0, 8'd0}, 1'b0, '0},
        '{'{OP_FRAME, 8'h5A, 1'b1, 8'd0}, 1'b1, '{ST_RESTART, 8'h00, 8'd0, 4'd0, 8'd0, 8'd0}},
        // byte written by the rejected frame is still in the store
        '{'{OP_READ,  8'h00, 1'b1, 8'd28}, 1'b0, '0}
    };

    // Advance the reassembly context by one transaction; return 1 when it gives a result
    function automatic bit reassemble_step(input frag_req_t r, output t_result res);
        int pos, addr, flen, idx, total, ep, proto, offset, want;
        bit fault;
        res = '0;
        if (r.op == OP_READ) begin
            res.status = ST_READ;
            if (r.ridx < REPORT_MAX) res.read_data = store_data[r.ridx[RA_W-1:0]];
        end else begin
            pos = frm_pos;
            if (pos < HDR_LEN) begin
                hdr[pos[1:0]] = r.data;
            end else begin
                addr = hdr[HDR_INDEX] * FRAG_DATA + pos - HDR_LEN;
                if (addr < REPORT_MAX) begin
                    store_data[addr[RA_W-1:0]]    = r.data;
                    store_written[addr[RA_W-1:0]] = 1'b1;
                end
            end
            if (!r.last) begin
                if (frm_pos != POS_MAX) frm_pos++;
                return 1'b0;
            end
            frm_pos = '0;
            flen    = pos + 1;
            idx     = hdr[HDR_INDEX];
            total   = hdr[HDR_TOTAL];
            ep      = hdr[HDR_EP];
            proto   = hdr[HDR_PROTO];
            offset  = idx * FRAG_DATA;
            want    = (total - offset > FRAG_DATA) ? FRAG_DATA : total - offset;
            // check frame size and header, then the sequence
            fault = flen < HDR_LEN + 1 || flen > POS_MAX || total == 0 || total > REPORT_MAX
                    || ep == 0 || ep > ENDPOINT_MAX || offset >= total
                    || flen - HDR_LEN != want;
            if (!fault && idx != 0)
                fault = !ctx_open || idx != ctx_next || total != ctx_len || ep != ctx_ep
                        || proto != ctx_proto;
            if (fault) begin
                ctx_len   = '0;
                ctx_done  = '0;
                ctx_next  = '0;
                ctx_ep    = '0;
                ctx_proto = '0;
                ctx_open  = 1'b0;
                res.status = ST_RESTART;
            end else begin
                if (idx == 0) begin
                    ctx_len   = 8'(total);
                    ctx_ep    = 4'(ep);
                    ctx_proto = 8'(proto);
                    ctx_open  = 1'b1;
                end
                ctx_done = 8'(offset + flen - HDR_LEN);
                ctx_next = 8'(idx + 1);
                if (ctx_done == ctx_len) begin
                    ctx_open   = 1'b0;
                    res.status = ST_COMPLETE;
                end else begin
                    res.status = ST_PROGRESS;
                end
            end
        end
        res.report_length  = ctx_len;
        res.endpoint       = ctx_ep;
        res.protocol_code  = ctx_proto;
        res.received_count = ctx_done;
        return 1'b1;
    endfunction

    // Idle cycles before a transaction, shared by both sides
    function automatic int draw_gap();
        if (steady_run || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 14);
    endfunction

    // Read a byte that was written, or one outside the report
    function automatic logic [7:0] pick_read_index();
        int a;
        a = $urandom_range(0, REPORT_MAX - 1);
        if (store_written[a[RA_W-1:0]] && $urandom_range(0, 3) != 0) return 8'(a);
        return 8'($urandom_range(REPORT_MAX, 254));
    endfunction

    function automatic void check_field(string name, int want, logic [7:0] got);
        if (got !== want[7:0]) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Drive one request transaction and record what it should produce
    task automatic push_item(input frag_req_t r, input bit typed, input t_result typed_res);
        int gap;
        bit has;
        t_result res;
        gap = draw_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.operation  <= r.op;
        req_if.frame_byte <= r.data;
        req_if.frame_last <= r.last;
        req_if.read_index <= r.ridx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        has = reassemble_step(r, res);
        if (has) pending_results.push_back(typed ? typed_res : res);
        sent_items++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        push_item('{OP_FRAME, b, last, 8'($urandom)}, 1'b0, '0);
    endtask

    task automatic send_read(input logic [7:0] idx);
        push_item('{OP_READ, 8'($urandom), 1'($urandom), idx}, 1'b0, '0);
    endtask

    // Send a header and dlen data bytes, with an occasional read slipped in
    task automatic send_frame(input logic [7:0] idx, total, ep, proto, input int dlen);
        logic [7:0] head [4];
        int n;
        head = '{idx, total, ep, proto};
        n = HDR_LEN + dlen;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) send_read(pick_read_index());
            send_byte(k < HDR_LEN ? head[k] : 8'($urandom), k == n - 1);
        end
    endtask

    // Response sink: stall a random number of cycles after each transaction
    always @(posedge i_clk) begin : sink_ctrl
        int gap;
        if (rsp_if.valid && rsp_if.ready) begin
            gap           = draw_gap();
            sink_wait    <= gap;
            rsp_if.ready <= (gap == 0);
        end else if (sink_wait > 0) begin
            sink_wait    <= sink_wait - 1;
            rsp_if.ready <= (sink_wait == 1);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d", $time, rsp_if.status);
                error_count++;
            end else begin
                front_res = pending_results.pop_front();
                check_field("status", int'(front_res.status), 8'(rsp_if.status));
                check_field("read_data", int'(front_res.read_data), rsp_if.read_data);
                check_field("report_length", int'(front_res.report_length),
                            rsp_if.report_length);
                check_field("endpoint", int'(front_res.endpoint), 8'(rsp_if.endpoint));
                check_field("protocol_code", int'(front_res.protocol_code),
                            rsp_if.protocol_code);
                check_field("received_count", int'(front_res.received_count),
                            rsp_if.received_count);
                status_seen[front_res.status]++;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int choice, total, ep, proto, nfrag, nsend, dlen;
        int f_idx, f_total, f_ep, f_proto;
        bit first;
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.operation  = OP_FRAME;
        req_if.frame_byte = '0;
        req_if.frame_last = 1'b0;
        req_if.read_index = '0;
        rsp_if.ready      = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            push_item(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].res);

        // Random part: mostly well-formed reports, some broken ones and noise
        first = 1'b1;
        while (sent_items < STIM_ITEMS) begin
            steady_run = ($urandom_range(0, 5) == 0);
            choice = first ? 0 : $urandom_range(0, 99);
            first = 1'b0;
            if (choice < 1) begin
                // frame at or near the length that saturates the byte counter
                send_frame(8'($urandom_range(0, 2)), 8'($urandom), 8'($urandom),
                           8'($urandom), $urandom_range(POS_MAX - HDR_LEN, POS_MAX));
            end else if (choice < 15) begin
                nsend = $urandom_range(1, 8);
                for (int k = 0; k < nsend; k++) send_byte(8'($urandom), k == nsend - 1);
            end else if (choice < 22) begin
                repeat ($urandom_range(1, 6)) send_read(pick_read_index());
            end else begin
                case ($urandom_range(0, 5))
                    0:       total = REPORT_MAX;
                    1:       total = $urandom_range(1, 3);
                    2:       total = FRAG_DATA + $urandom_range(0, 1);
                    3:       total = 2 * FRAG_DATA + $urandom_range(0, 1);
                    default: total = $urandom_range(1, REPORT_MAX);
                endcase
                ep    = $urandom_range(1, ENDPOINT_MAX);
                proto = $urandom_range(0, 255);
                nfrag = (total + FRAG_DATA - 1) / FRAG_DATA;
                nsend = ($urandom_range(0, 4) == 0) ? $urandom_range(1, nfrag) : nfrag;
                for (int i = 0; i < nsend; i++) begin
                    f_idx   = i;
                    f_total = total;
                    f_ep    = ep;
                    f_proto = proto;
                    dlen    = (total - i * FRAG_DATA > FRAG_DATA) ? FRAG_DATA
                                                                  : total - i * FRAG_DATA;
                    // corrupt one fragment now and then
                    case ($urandom_range(0, 24))
                        0: dlen = (dlen > 0 && $urandom_range(0, 1) == 1) ? dlen - 1 : dlen + 1;
                        1: f_total = $urandom_range(0, 255);
                        2: f_ep = $urandom_range(0, 255);
                        3: f_proto = $urandom_range(0, 255);
                        4: f_idx = ($urandom_range(0, 1) == 1) ? i + 1 : $urandom_range(0, 255);
                        5: f_idx = 0;
                        default: ;
                    endcase
                    send_frame(8'(f_idx), 8'(f_total), 8'(f_ep), 8'(f_proto), dlen);
                end
            end
        end
        req_if.valid <= 1'b0;

        // Drain the response queue, then let the pipeline settle
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d requests sent; results: %0d in progress, %0d complete, %0d restart",
                 sent_items, status_seen[ST_PROGRESS], status_seen[ST_COMPLETE],
                 status_seen[ST_RESTART]);
        $display("tb: %0d read replies, %0d mismatches", status_seen[ST_READ], error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/frasm_pkg.sv
hw/rtl/frasm_if.sv
hw/rtl/frasm_outq.sv
hw/rtl/fragment_reassembler.sv
verif/tb_fragment_reassembler.sv
